[rtl/fat12_cluster_chain_step_unit_macros.svh]
// Assertion helpers for the FAT12 cluster chain step unit.
// Both macros sample on clock and are switched off while reset is high.
`ifndef FAT12_CLUSTER_CHAIN_STEP_UNIT_MACROS_SVH
`define FAT12_CLUSTER_CHAIN_STEP_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FAT12_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FAT12_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/fat12_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package fat12_pkg;

   // Table size default and fixed field widths
   localparam int TABLE_BYTES_DEF = 8192;
   localparam int ADDR_W          = 13;
   localparam int LOADED_W        = 14;
   localparam int BYTE_W          = 8;
   localparam int CLUSTER_W       = 12;
   localparam int SECTOR_W        = 24;
   localparam int PRODUCT_W       = 20;
   localparam int CSR_INDEX_W     = 3;
   localparam int CSR_DATA_W      = 16;
   localparam int ROOT_BYTES_W    = 21;
   localparam int DIR_ENTRY_SHIFT = 5;
   localparam int ODD_SHIFT       = 4;

   localparam logic [CLUSTER_W-1:0] CHAIN_END_MIN = 12'hFF8;
   localparam logic [CLUSTER_W-1:0] FIRST_CLUSTER = 12'd2;

   // Item kinds
   localparam logic KIND_LOAD   = 1'b0;
   localparam logic KIND_LOOKUP = 1'b1;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_RESERVED_SECTORS  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SECTORS_PER_TABLE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_TABLE_COPIES      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ROOT_ENTRIES      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_SECTOR_BYTES      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_CLUSTER_SECTORS   = 3'd5;

   // Register reset values
   localparam int RST_RESERVED_SECTORS  = 1;
   localparam int RST_SECTORS_PER_TABLE = 9;
   localparam int RST_TABLE_COPIES      = 2;
   localparam int RST_ROOT_ENTRIES      = 224;
   localparam int RST_SECTOR_BYTES      = 512;
   localparam int RST_CLUSTER_SECTORS   = 1;

   localparam int RST_ROOT_SECS = (RST_ROOT_ENTRIES * 32 + RST_SECTOR_BYTES - 1)
                                  / RST_SECTOR_BYTES;
   localparam int RST_DATA_START = RST_RESERVED_SECTORS
                                   + RST_SECTORS_PER_TABLE * RST_TABLE_COPIES
                                   + RST_ROOT_SECS;

   // Registers that feed the data start calculation
   typedef struct packed {
      logic [15:0] reserved_sectors;
      logic [7:0]  sectors_per_table;
      logic [2:0]  table_copies;
      logic [15:0] root_entries;
      logic [12:0] sector_bytes;
   } ds_cfg_type;

   // Table write port
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [BYTE_W-1:0] data;
   } tbl_wr_type;

   // Table pair read port: idx is the byte offset of the low byte
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] idx;
   } tbl_rd_type;

endpackage

`default_nettype wire

[rtl/fat12_tbl.sv]
`timescale 1ns / 1ps
`default_nettype none

// Allocation table store, split into even and odd byte banks so that a
// 12-bit entry pair is read in a single registered access.
module fat12_tbl import fat12_pkg::*; #(
   parameter int TABLE_BYTES = TABLE_BYTES_DEF
) (
   input  wire logic              clock,
   input  wire tbl_wr_type        wr,
   input  wire tbl_rd_type        rd,
   output logic [BYTE_W-1:0]      lo_byte,
   output logic [BYTE_W-1:0]      hi_byte
);

   localparam int BANK_DEPTH = (TABLE_BYTES + 1) / 2;
   localparam int ROW_W      = $clog2(BANK_DEPTH);

   logic [BYTE_W-1:0] even_mem [BANK_DEPTH];
   logic [BYTE_W-1:0] odd_mem  [BANK_DEPTH];

   logic [BYTE_W-1:0] rd_even_ff;
   logic [BYTE_W-1:0] rd_odd_ff;
   logic              swap_ff;
   logic [ADDR_W-1:0] even_addr;

   // Odd pair start: low byte in odd bank, high byte in next even row
   assign even_addr = rd.idx + {{(ADDR_W-1){1'b0}}, rd.idx[0]};

   // Even bank
   always_ff @(posedge clock) begin
      if (wr.en && !wr.addr[0]) begin
         even_mem[wr.addr[ROW_W:1]] <= wr.data;
      end
      if (rd.en) begin
         rd_even_ff <= even_mem[even_addr[ROW_W:1]];
      end
   end

   // Odd bank
   always_ff @(posedge clock) begin
      if (wr.en && wr.addr[0]) begin
         odd_mem[wr.addr[ROW_W:1]] <= wr.data;
      end
      if (rd.en) begin
         rd_odd_ff <= odd_mem[rd.idx[ROW_W:1]];
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         swap_ff <= rd.idx[0];
      end
   end

   assign lo_byte = swap_ff ? rd_odd_ff  : rd_even_ff;
   assign hi_byte = swap_ff ? rd_even_ff : rd_odd_ff;

endmodule

`default_nettype wire

[rtl/fat12_ds_calc.sv]
`timescale 1ns / 1ps
`default_nettype none

// Data region start: reserved + table sectors + root directory sectors
// rounded up. The root term uses a restoring divider, one quotient bit
// per cycle, followed by a sum state that adds the terms.
module fat12_ds_calc import fat12_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire ds_cfg_type    cfg,
   output logic [SECTOR_W-1:0] data_start,
   output logic               busy
);

   typedef enum logic [2:0] {
      DS_IDLE   = 3'b001,
      DS_DIVIDE = 3'b010,
      DS_SUM    = 3'b100
   } ds_state_type;

   localparam int COUNT_W = $clog2(ROOT_BYTES_W);
   localparam int REM_W   = 13;

   ds_state_type            state_ff, state_in;
   logic [COUNT_W-1:0]      count_ff, count_in;
   logic [REM_W-1:0]        rem_ff, rem_in;
   logic [ROOT_BYTES_W-1:0] quot_ff, quot_in;
   logic [SECTOR_W-1:0]     data_start_ff, data_start_in;

   logic [REM_W:0]          rem_shift;
   logic [REM_W:0]          rem_sub;
   logic                    fits;
   logic [ROOT_BYTES_W:0]   root_secs;
   logic [10:0]             table_secs;

   // One restoring step
   assign rem_shift = {rem_ff, quot_ff[ROOT_BYTES_W-1]};
   assign rem_sub   = rem_shift - {1'b0, cfg.sector_bytes};
   assign fits      = rem_shift >= {1'b0, cfg.sector_bytes};

   // Final terms; a zero sector size counts the root directory as empty
   assign table_secs = 11'(cfg.sectors_per_table) * 11'(cfg.table_copies);
   always_comb begin
      root_secs = '0;
      if (cfg.sector_bytes != '0) begin
         root_secs = {1'b0, quot_ff} + {{ROOT_BYTES_W{1'b0}}, (rem_ff != '0)};
      end
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rem_in        = rem_ff;
      quot_in       = quot_ff;
      data_start_in = data_start_ff;
      case (state_ff)
         DS_IDLE: begin
         end
         DS_DIVIDE: begin
            rem_in   = fits ? rem_sub[REM_W-1:0] : rem_shift[REM_W-1:0];
            quot_in  = {quot_ff[ROOT_BYTES_W-2:0], fits};
            count_in = count_ff - COUNT_W'(1);
            if (count_ff == '0) begin
               state_in = DS_SUM;
            end
         end
         DS_SUM: begin
            data_start_in = SECTOR_W'({8'd0, cfg.reserved_sectors})
                            + SECTOR_W'(table_secs)
                            + SECTOR_W'(root_secs);
            state_in      = DS_IDLE;
         end
         default: begin
            state_in = DS_IDLE;
         end
      endcase
      // A new register write restarts the calculation
      if (start) begin
         state_in = DS_DIVIDE;
         count_in = COUNT_W'(ROOT_BYTES_W - 1);
         rem_in   = '0;
         quot_in  = {cfg.root_entries, {DIR_ENTRY_SHIFT{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= DS_IDLE;
         data_start_ff <= SECTOR_W'(RST_DATA_START);
      end else begin
         state_ff      <= state_in;
         data_start_ff <= data_start_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      rem_ff   <= rem_in;
      quot_ff  <= quot_in;
   end

   assign data_start = data_start_ff;
   assign busy       = start || (state_ff != DS_IDLE);

endmodule

`default_nettype wire

[rtl/fat12_cluster_chain_step_unit.sv]
// FAT12 cluster chain step unit.
// Request channel (req_*): a load beat writes one byte of the allocation
// table; a lookup beat names a cluster. Every request beat yields exactly
// one response beat (rsp_*), in order. A load answers all zeros. A lookup
// answers the cluster's first sector, its 12-bit table entry, an end of
// chain flag and a bad lookup flag (cluster below 2 or entry not loaded).
// A new beat is taken every cycle while req_stall is low. The pipeline is a
// table read stage, a multiply and entry extract stage, and the output
// register, which drives response valid.
// A csr write starts a recalculation of the data region start; req_stall
// stays high from the write through the start, 21 divider steps and
// the sum state. Reset clears the pipeline, sets the registers to their
// defaults and the data start to 33; the table contents are undefined
// until loaded. When rsp_stall is high the response holds, and the stages
// behind it keep filling until the first one is full, then req_stall rises.
`timescale 1ns / 1ps
`default_nettype none
`include "fat12_cluster_chain_step_unit_macros.svh"

module fat12_cluster_chain_step_unit import fat12_pkg::*; #(
   parameter int TABLE_BYTES = TABLE_BYTES_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // configuration
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data,
   // requests
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic                   req_kind,
   input  wire logic [ADDR_W-1:0]      req_table_address,
   input  wire logic [BYTE_W-1:0]      req_table_byte,
   input  wire logic [CLUSTER_W-1:0]   req_cluster,
   // responses
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [SECTOR_W-1:0]         rsp_first_sector,
   output logic [CLUSTER_W-1:0]        rsp_next_cluster,
   output logic                        rsp_chain_end,
   output logic                        rsp_bad_lookup
);

   localparam logic [LOADED_W-1:0] TABLE_LIMIT = LOADED_W'(TABLE_BYTES);

   // Configuration registers
   logic [15:0] reserved_sectors_ff;
   logic [7:0]  sectors_per_table_ff;
   logic [2:0]  table_copies_ff;
   logic [15:0] root_entries_ff;
   logic [12:0] sector_bytes_ff;
   logic [7:0]  cluster_sectors_ff;
   logic        cfg_start_ff;

   ds_cfg_type          ds_cfg;
   logic [SECTOR_W-1:0] data_start;
   logic                ds_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         reserved_sectors_ff  <= 16'(RST_RESERVED_SECTORS);
         sectors_per_table_ff <= 8'(RST_SECTORS_PER_TABLE);
         table_copies_ff      <= 3'(RST_TABLE_COPIES);
         root_entries_ff      <= 16'(RST_ROOT_ENTRIES);
         sector_bytes_ff      <= 13'(RST_SECTOR_BYTES);
         cluster_sectors_ff   <= 8'(RST_CLUSTER_SECTORS);
         cfg_start_ff         <= 1'b0;
      end else begin
         cfg_start_ff <= csr_write_enable;
         if (csr_write_enable) begin
            case (csr_index)
               REG_RESERVED_SECTORS:  reserved_sectors_ff  <= csr_write_data;
               REG_SECTORS_PER_TABLE: sectors_per_table_ff <= csr_write_data[7:0];
               REG_TABLE_COPIES:      table_copies_ff      <= csr_write_data[2:0];
               REG_ROOT_ENTRIES:      root_entries_ff      <= csr_write_data;
               REG_SECTOR_BYTES:      sector_bytes_ff      <= csr_write_data[12:0];
               REG_CLUSTER_SECTORS:   cluster_sectors_ff   <= csr_write_data[7:0];
               default: begin
               end
            endcase
         end
      end
   end

   assign ds_cfg = '{
      reserved_sectors:  reserved_sectors_ff,
      sectors_per_table: sectors_per_table_ff,
      table_copies:      table_copies_ff,
      root_entries:      root_entries_ff,
      sector_bytes:      sector_bytes_ff
   };

   fat12_ds_calc u_ds_calc (
      .clock      (clock),
      .reset      (reset),
      .start      (cfg_start_ff),
      .cfg        (ds_cfg),
      .data_start (data_start),
      .busy       (ds_busy)
   );

   // Handshake: each stage takes a beat when empty or when it drains
   logic s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   logic ready1, ready2, ready3;
   logic accept;

   assign ready3    = !rsp_valid_ff || !rsp_stall;
   assign ready2    = !s2_valid_ff || ready3;
   assign ready1    = !s1_valid_ff || ready2;
   assign req_stall = !ready1 || ds_busy || csr_write_enable;
   assign accept    = req_valid && !req_stall;

   // Stage 0: decode, table write, table read and range check
   logic [ADDR_W-1:0]   pair_idx;
   logic [LOADED_W-1:0] pair_end;
   logic [LOADED_W-1:0] load_end;
   logic                load_hit;
   logic                lookup_bad;
   logic [LOADED_W-1:0] loaded_bytes_ff, loaded_bytes_in;
   tbl_wr_type          tbl_wr;
   tbl_rd_type          tbl_rd;
   logic [BYTE_W-1:0]   lo_byte, hi_byte;

   assign pair_idx   = {1'b0, req_cluster} + {2'b00, req_cluster[CLUSTER_W-1:1]};
   assign pair_end   = {1'b0, pair_idx} + LOADED_W'(1);
   assign load_end   = {1'b0, req_table_address} + LOADED_W'(1);
   assign load_hit   = accept && (req_kind == KIND_LOAD)
                       && ({1'b0, req_table_address} < TABLE_LIMIT);
   assign lookup_bad = (req_cluster < FIRST_CLUSTER) || (pair_end >= loaded_bytes_ff)
                       || (pair_end >= TABLE_LIMIT);

   assign tbl_wr = '{en: load_hit, addr: req_table_address, data: req_table_byte};
   assign tbl_rd = '{en: accept && (req_kind == KIND_LOOKUP), idx: pair_idx};

   fat12_tbl #(
      .TABLE_BYTES (TABLE_BYTES)
   ) u_tbl (
      .clock   (clock),
      .wr      (tbl_wr),
      .rd      (tbl_rd),
      .lo_byte (lo_byte),
      .hi_byte (hi_byte)
   );

   // Fill mark: one past the highest byte loaded
   always_comb begin
      loaded_bytes_in = loaded_bytes_ff;
      if (load_hit && (load_end > loaded_bytes_ff)) begin
         loaded_bytes_in = load_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_bytes_ff <= '0;
      end else begin
         loaded_bytes_ff <= loaded_bytes_in;
      end
   end

   // Stage 1 registers
   logic                 s1_lookup_ff, s1_bad_ff, s1_odd_ff;
   logic [CLUSTER_W-1:0] s1_offset_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_lookup_ff <= (req_kind == KIND_LOOKUP);
         s1_bad_ff    <= lookup_bad;
         s1_odd_ff    <= req_cluster[0];
         s1_offset_ff <= req_cluster - FIRST_CLUSTER;
      end
   end

   // Stage 1 -> 2: entry extraction and sector offset multiply
   logic [15:0]          pair;
   logic [15:0]          pair_shift;
   logic [CLUSTER_W-1:0] entry_in;
   logic                 s2_ok_ff, s2_bad_ff;
   logic [CLUSTER_W-1:0] s2_next_ff;
   logic [PRODUCT_W-1:0] s2_product_ff;

   assign pair       = {hi_byte, lo_byte};
   assign pair_shift = pair >> ODD_SHIFT;
   assign entry_in   = s1_odd_ff ? pair_shift[CLUSTER_W-1:0] : pair[CLUSTER_W-1:0];

   always_ff @(posedge clock) begin
      if (s1_valid_ff && ready2) begin
         s2_ok_ff      <= s1_lookup_ff && !s1_bad_ff;
         s2_bad_ff     <= s1_lookup_ff && s1_bad_ff;
         s2_next_ff    <= entry_in;
         s2_product_ff <= PRODUCT_W'(s1_offset_ff) * PRODUCT_W'(cluster_sectors_ff);
      end
   end

   // Stage 2 -> output register: sector sum and flags
   logic [SECTOR_W-1:0]  rsp_first_sector_ff;
   logic [CLUSTER_W-1:0] rsp_next_cluster_ff;
   logic                 rsp_chain_end_ff, rsp_bad_lookup_ff;

   always_ff @(posedge clock) begin
      if (s2_valid_ff && ready3) begin
         rsp_first_sector_ff <= s2_ok_ff ? data_start + SECTOR_W'(s2_product_ff) : '0;
         rsp_next_cluster_ff <= s2_ok_ff ? s2_next_ff : '0;
         rsp_chain_end_ff    <= s2_ok_ff && (s2_next_ff >= CHAIN_END_MIN);
         rsp_bad_lookup_ff   <= s2_bad_ff;
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ready1) begin
            s1_valid_ff <= accept;
         end
         if (ready2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (ready3) begin
            rsp_valid_ff <= s2_valid_ff;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_first_sector = rsp_first_sector_ff;
   assign rsp_next_cluster = rsp_next_cluster_ff;
   assign rsp_chain_end    = rsp_chain_end_ff;
   assign rsp_bad_lookup   = rsp_bad_lookup_ff;

   // Checks
   `FAT12_ASSERT_SAME(a_bad_zero, rsp_valid_ff && rsp_bad_lookup_ff, (rsp_first_sector_ff == '0) && (rsp_next_cluster_ff == '0) && !rsp_chain_end_ff, "bad lookup beat carries data")
   `FAT12_ASSERT_SAME(a_chain_end, rsp_valid_ff && rsp_chain_end_ff, rsp_next_cluster_ff >= CHAIN_END_MIN, "chain end without end marker")
   `FAT12_ASSERT_NEXT(a_fill_mark, load_hit, loaded_bytes_ff > LOADED_W'($past(req_table_address)), "fill mark behind loaded byte")
   `FAT12_ASSERT_NEXT(a_cfg_hold, csr_write_enable, req_stall, "request taken during data start update")

endmodule

`default_nettype wire
